### src/allm_pkg.sv
// Package for the array linked list manager: sizes, command and status codes,
// sequencer states. No dependencies.
`default_nettype none
package allm_pkg;
  localparam int SLOTS      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int SW         = $clog2(SLOTS);
  localparam int PW         = SW + 1;

  typedef logic [PW-1:0]         ptr_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  localparam ptr_t NIL = ptr_t'(SLOTS);

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_RM_FRONT  = 3'd2,
    CMD_RM_REAR   = 3'd3,
    CMD_RM_CUR    = 3'd4,
    CMD_SEARCH    = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_READ_CUR  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOCUR    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_STEP, S_NEWPAY, S_NEWLINK, S_TAILLINK, S_FREE,
    S_RDCUR, S_WAITCUR, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    WALK_SCAN, WALK_DROP, WALK_UNLINK
  } walk_t;

  typedef enum logic [1:0] {
    MEM_PAYLOAD, MEM_LINK, MEM_FREE
  } mem_sel_t;

  typedef struct packed {
    logic     we;
    mem_sel_t sel;
    ptr_t     addr;
    ptr_t     wptr;
    data_t    wdata;
  } mem_req_t;
endpackage
`default_nettype wire

### src/allm_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on allm_pkg.
`default_nettype none
interface allm_in_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              cmd;
  logic [allm_pkg::DATA_WIDTH-1:0] data;
  modport source (output valid, cmd, data, input ready);
  modport sink   (input valid, cmd, data, output ready);
endinterface

interface allm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  slot;
  logic        slot_valid;
  logic [allm_pkg::DATA_WIDTH-1:0] node_data;
  modport source (output valid, status, slot, slot_valid, node_data, input ready);
  modport sink   (input valid, status, slot, slot_valid, node_data, output ready);
endinterface
`default_nettype wire

### src/allm_store.sv
// Slot store: payload, link and free-link memories, one access per cycle,
// registered read data. Depends on allm_pkg.
`default_nettype none
module allm_store (
  input  wire logic               clk,
  input  wire allm_pkg::mem_req_t req,
  output allm_pkg::data_t         rdata,
  output allm_pkg::ptr_t          rlink,
  output allm_pkg::ptr_t          rfree
);
  import allm_pkg::*;
  data_t pay_mem  [SLOTS];
  ptr_t  link_mem [SLOTS];
  ptr_t  free_mem [SLOTS];
  logic [SW-1:0] a;
  assign a = req.addr[SW-1:0];

  always_ff @(posedge clk) begin
    if (req.we && req.sel == MEM_PAYLOAD) pay_mem[a] <= req.wdata;
    if (req.we && req.sel == MEM_LINK)    link_mem[a] <= req.wptr;
    if (req.we && req.sel == MEM_FREE)    free_mem[a] <= req.wptr;
    rdata <= pay_mem[a];
    rlink <= link_mem[a];
    rfree <= free_mem[a];
  end
endmodule
`default_nettype wire

### src/allm_cfg.sv
// APB-style register file holding the search compare mask.
// Depends on nothing beyond the clock and reset.
`default_nettype none
module allm_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [31:0]      mask
);
  logic [31:0] mask_r;
  logic        sel0;
  assign sel0   = (paddr == 2'd0);
  assign pready = 1'b1;
  assign mask   = mask_r;
  assign prdata = sel0 ? mask_r : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '1;
    else if (psel && penable && pwrite && sel0) mask_r <= pwdata;
  end
endmodule
`default_nettype wire

### src/allm_seq.sv
// Command sequencer: walks the links one memory read per step, updates head,
// current, free list and high-water mark. Depends on allm_pkg, allm_store.
`default_nettype none
module allm_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire allm_pkg::data_t in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot,
  output logic             out_slot_valid,
  output allm_pkg::data_t  out_node_data,
  input  wire logic [31:0] mask
);
  import allm_pkg::*;

  state_t  state_r, state_nxt;
  walk_t   ph_r, ph_nxt;
  cmd_t    cmd_r, cmd_nxt;
  data_t   d_r, d_nxt;
  ptr_t    head_r, head_nxt, cur_r, cur_nxt, fh_r, fh_nxt;
  logic [PW-1:0] hw_r, hw_nxt;
  ptr_t    p_r, p_nxt, pre_r, pre_nxt, rel_r, rel_nxt;
  logic [PW-1:0] n_r, n_nxt;
  status_t st_r, st_nxt;
  data_t   od_r, od_nxt;
  mem_req_t req;
  data_t   rdata;
  ptr_t    rlink, rfree;
  data_t   dmask;
  logic    can_take;
  ptr_t    new_slot;

  allm_store u_store (.clk(clk), .req(req), .rdata(rdata), .rlink(rlink), .rfree(rfree));

  assign dmask = data_t'(mask);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_slot_valid = !cur_r[SW];
  assign out_slot = out_slot_valid ? 8'(cur_r[SW-1:0]) : 8'd0;
  assign out_node_data = out_slot_valid ? od_r : '0;
  assign can_take = !fh_r[SW] || (hw_r < PW'(SLOTS));
  assign new_slot = fh_r[SW] ? hw_r : fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= NIL; cur_r <= NIL; fh_r <= NIL; hw_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; cur_r <= cur_nxt; fh_r <= fh_nxt; hw_r <= hw_nxt;
    end
    cmd_r <= cmd_nxt; d_r <= d_nxt; p_r <= p_nxt; pre_r <= pre_nxt; ph_r <= ph_nxt;
    rel_r <= rel_nxt; n_r <= n_nxt; st_r <= st_nxt; od_r <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; cmd_nxt = cmd_r; d_nxt = d_r;
    head_nxt = head_r; cur_nxt = cur_r; fh_nxt = fh_r; hw_nxt = hw_r;
    p_nxt = p_r; pre_nxt = pre_r; rel_nxt = rel_r; n_nxt = n_r;
    st_nxt = st_r; od_nxt = od_r;
    req = '{we: 1'b0, sel: MEM_LINK, addr: p_r, wptr: NIL, wdata: d_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = cmd_t'(in_cmd); d_nxt = in_data;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_nxt = ST_OK;
        state_nxt = S_RDCUR;
        p_nxt = head_r; pre_nxt = NIL; n_nxt = '0; ph_nxt = WALK_SCAN;
        unique case (cmd_r)
          CMD_INS_FRONT, CMD_INS_REAR: begin
            if (!can_take) st_nxt = ST_FULL;
            else if (cmd_r == CMD_INS_REAR && !head_r[SW]) state_nxt = S_RD;
            else state_nxt = S_NEWPAY;
          end
          CMD_RM_FRONT, CMD_RM_REAR, CMD_RM_CUR: begin
            if (head_r[SW]) st_nxt = ST_EMPTY;
            else if (cmd_r == CMD_RM_CUR && cur_r[SW]) st_nxt = ST_NOCUR;
            else begin
              state_nxt = S_RD;
              if (cmd_r == CMD_RM_FRONT || (cmd_r == CMD_RM_CUR && cur_r == head_r))
                ph_nxt = WALK_DROP;
            end
          end
          CMD_SEARCH: begin
            if (head_r[SW]) st_nxt = ST_NOTFOUND;
            else state_nxt = S_RD;
          end
          CMD_CLEAR: begin
            cur_nxt = NIL;
            if (!head_r[SW]) begin state_nxt = S_RD; ph_nxt = WALK_DROP; end
          end
          default: if (cur_r[SW]) st_nxt = ST_NOCUR;
        endcase
      end
      S_RD: begin
        req.addr = p_r;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        state_nxt = S_RD;
        unique case (ph_r)
          WALK_DROP: begin
            head_nxt = rlink; cur_nxt = rlink; rel_nxt = p_r; p_nxt = rlink;
            state_nxt = S_FREE;
          end
          WALK_UNLINK: begin
            // p_r is current, rlink its successor
            req = '{we: 1'b1, sel: MEM_LINK, addr: pre_r, wptr: rlink, wdata: d_r};
            rel_nxt = cur_r; cur_nxt = pre_r; state_nxt = S_FREE;
          end
          default: begin
            unique case (cmd_r)
              CMD_SEARCH: begin
                if (((rdata ^ d_r) & dmask) == '0) begin
                  cur_nxt = p_r; state_nxt = S_RDCUR;
                end else if (rlink[SW] || n_r == PW'(SLOTS - 1)) begin
                  st_nxt = ST_NOTFOUND; state_nxt = S_RDCUR;
                end else begin
                  p_nxt = rlink; n_nxt = n_r + 1'b1;
                end
              end
              CMD_INS_REAR: begin
                if (rlink[SW] || n_r == PW'(SLOTS)) state_nxt = S_NEWPAY;
                else begin p_nxt = rlink; n_nxt = n_r + 1'b1; end
              end
              CMD_RM_REAR: begin
                if (pre_r[SW] && rlink[SW]) begin
                  head_nxt = rlink; cur_nxt = rlink; rel_nxt = p_r;
                  state_nxt = S_FREE;
                end else if (pre_r[SW]) begin
                  pre_nxt = p_r; p_nxt = rlink;
                end else if (rlink[SW] || n_r == PW'(SLOTS)) begin
                  req = '{we: 1'b1, sel: MEM_LINK, addr: pre_r, wptr: NIL, wdata: d_r};
                  cur_nxt = pre_r; rel_nxt = p_r; state_nxt = S_FREE;
                end else begin
                  pre_nxt = p_r; p_nxt = rlink; n_nxt = n_r + 1'b1;
                end
              end
              CMD_RM_CUR: begin
                if (rlink == cur_r) begin
                  pre_nxt = p_r; p_nxt = cur_r; ph_nxt = WALK_UNLINK;
                end else if (rlink[SW] || n_r == PW'(SLOTS)) begin
                  state_nxt = S_RDCUR;
                end else begin
                  p_nxt = rlink; n_nxt = n_r + 1'b1;
                end
              end
              default: state_nxt = S_RDCUR;
            endcase
          end
        endcase
      end
      S_NEWPAY: begin
        req = '{we: 1'b1, sel: MEM_PAYLOAD, addr: new_slot, wptr: NIL, wdata: d_r};
        rel_nxt = new_slot;
        if (fh_r[SW]) hw_nxt = hw_r + 1'b1;
        state_nxt = S_NEWLINK;
      end
      S_NEWLINK: begin
        if (!fh_r[SW]) fh_nxt = rfree;
        cur_nxt = rel_r;
        if (cmd_r == CMD_INS_REAR && !head_r[SW]) begin
          req = '{we: 1'b1, sel: MEM_LINK, addr: rel_r, wptr: NIL, wdata: d_r};
          state_nxt = S_TAILLINK;
        end else begin
          req = '{we: 1'b1, sel: MEM_LINK, addr: rel_r, wptr: head_r, wdata: d_r};
          head_nxt = rel_r;
          state_nxt = S_RDCUR;
        end
      end
      S_TAILLINK: begin
        req = '{we: 1'b1, sel: MEM_LINK, addr: p_r, wptr: rel_r, wdata: d_r};
        state_nxt = S_RDCUR;
      end
      S_FREE: begin
        req = '{we: 1'b1, sel: MEM_FREE, addr: rel_r, wptr: fh_r, wdata: d_r};
        fh_nxt = rel_r;
        state_nxt = S_RDCUR;
        if (cmd_r == CMD_CLEAR) begin
          n_nxt = n_r + 1'b1;
          if (!p_r[SW] && n_r < PW'(SLOTS - 1)) state_nxt = S_RD;
          else begin head_nxt = NIL; cur_nxt = NIL; end
        end
      end
      S_RDCUR: begin
        if (cur_r[SW]) begin
          od_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          req.addr = cur_r;
          state_nxt = S_WAITCUR;
        end
      end
      S_WAITCUR: begin
        state_nxt = S_OUT;
        od_nxt = rdata;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/array_linked_list_manager_core.sv
// Top level of the array linked list manager: channels, config port, sequencer.
// Depends on allm_pkg, allm_if, allm_cfg, allm_seq.
//
//  channel | dir | handshake         | words
//  in_     | in  | valid/ready       | cmd, data
//  out_    | out | valid/ready       | status, slot, slot_valid, node_data
//  cfg_    | in  | APB, pready=1     | compare_mask at 0x0
//
// One command at a time, paced by the single-port slot store; a link walk step
// is an address state and a registered read (S_RD, S_STEP), each slot release
// adds a free write (S_FREE), so a clear of a full list is the longest command.
// Reset is synchronous, no clearing pass. A stalled result holds the block.
`default_nettype none
module array_linked_list_manager_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  allm_in_if.sink          in_ch,
  allm_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import allm_pkg::*;
  logic [31:0] mask;

  allm_cfg u_cfg (.clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .mask(mask));

  allm_seq u_seq (.clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .in_data(in_ch.data), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_status(out_ch.status), .out_slot(out_ch.slot),
    .out_slot_valid(out_ch.slot_valid), .out_node_data(out_ch.node_data), .mask(mask));

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= 3'd4) else $error("bad status");
  a_nocur_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.slot_valid) |-> out_ch.node_data == '0)
    else $error("data without current node");
`endif
endmodule
`default_nettype wire

### verif/tb_array_linked_list_manager_core.sv
// Testbench for array_linked_list_manager_core: directed and random command
// streams checked word by word against an in-bench list predictor.
// Depends on allm_pkg, allm_if and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module tb_array_linked_list_manager_core;
  import allm_pkg::*;

  localparam logic [1:0] REG_COMPARE_MASK = 2'd0;
  localparam longint     CYCLE_LIMIT      = 10_000_000;
  localparam int         IDLE_PCT         = 38;

  typedef struct {
    status_t    status;
    logic [7:0] slot;
    logic       slot_valid;
    data_t      node_data;
  } node_view_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  allm_in_if  in_ch ();
  allm_out_if out_ch ();

  array_linked_list_manager_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // list predictor state
  data_t   slot_data [SLOTS];
  ptr_t    next_slot [SLOTS];
  ptr_t    next_free [SLOTS];
  ptr_t    list_head, cur_node, free_top, fresh_count;
  data_t   key_mask;

  node_view_t pending_views[$];
  int         fail_count = 0;
  int         words_sent;
  int         words_checked = 0;
  longint     cycle_count = 0;
  bit         calm;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic ptr_t succ(ptr_t p);
    return (p != NIL) ? next_slot[p[SW-1:0]] : NIL;
  endfunction

  function automatic ptr_t grab_slot();
    ptr_t s;
    if (free_top != NIL) begin
      s = free_top;
      free_top = next_free[s[SW-1:0]];
    end else begin
      s = fresh_count;
      fresh_count = fresh_count + 1'b1;
    end
    return s;
  endfunction

  function automatic void release_slot(ptr_t s);
    if (s != NIL) begin
      next_free[s[SW-1:0]] = free_top;
      free_top = s;
    end
  endfunction

  function automatic void push_front(data_t d);
    ptr_t s;
    s = grab_slot();
    slot_data[s[SW-1:0]] = d;
    next_slot[s[SW-1:0]] = list_head;
    list_head = s;
    cur_node = s;
  endfunction

  function automatic void pop_front();
    ptr_t old;
    old = list_head;
    cur_node = succ(old);
    release_slot(old);
    list_head = cur_node;
  endfunction

  function automatic int list_length();
    ptr_t p;
    int n;
    p = list_head;
    n = 0;
    while (p != NIL && n < SLOTS) begin
      n++;
      p = succ(p);
    end
    return n;
  endfunction

  function automatic status_t apply_command(cmd_t c, data_t d);
    ptr_t p, pre, s;
    int n;
    case (c)
      CMD_INS_FRONT, CMD_INS_REAR: begin
        if (free_top == NIL && fresh_count >= SLOTS) return ST_FULL;
        if (c == CMD_INS_FRONT || list_head == NIL) begin
          push_front(d);
          return ST_OK;
        end
        p = list_head;
        for (n = 0; n < SLOTS && succ(p) != NIL; n++) p = succ(p);
        s = grab_slot();
        slot_data[s[SW-1:0]] = d;
        next_slot[s[SW-1:0]] = NIL;
        next_slot[p[SW-1:0]] = s;
        cur_node = s;
        return ST_OK;
      end
      CMD_RM_FRONT: begin
        if (list_head == NIL) return ST_EMPTY;
        pop_front();
        return ST_OK;
      end
      CMD_RM_REAR: begin
        if (list_head == NIL) return ST_EMPTY;
        if (succ(list_head) == NIL) begin
          pop_front();
          return ST_OK;
        end
        pre = list_head;
        p = succ(list_head);
        for (n = 0; n < SLOTS && succ(p) != NIL; n++) begin
          pre = p;
          p = succ(p);
        end
        next_slot[pre[SW-1:0]] = NIL;
        cur_node = pre;
        release_slot(p);
        return ST_OK;
      end
      CMD_RM_CUR: begin
        if (list_head == NIL) return ST_EMPTY;
        if (cur_node == NIL) return ST_NOCUR;
        if (list_head == cur_node) begin
          pop_front();
          return ST_OK;
        end
        p = list_head;
        for (n = 0; n < SLOTS && p != NIL && succ(p) != cur_node; n++) p = succ(p);
        if (p == NIL || succ(p) != cur_node) return ST_OK;
        next_slot[p[SW-1:0]] = succ(cur_node);
        release_slot(cur_node);
        cur_node = p;
        return ST_OK;
      end
      CMD_SEARCH: begin
        p = list_head;
        for (n = 0; n < SLOTS && p != NIL; n++) begin
          if (((slot_data[p[SW-1:0]] ^ d) & key_mask) == '0) begin
            cur_node = p;
            return ST_OK;
          end
          p = succ(p);
        end
        return ST_NOTFOUND;
      end
      CMD_CLEAR: begin
        for (n = 0; n < SLOTS && list_head != NIL; n++) pop_front();
        list_head = NIL;
        cur_node = NIL;
        return ST_OK;
      end
      default: return (cur_node != NIL) ? ST_OK : ST_NOCUR;
    endcase
  endfunction

  function automatic void predict_view(cmd_t c, data_t d);
    node_view_t v;
    v.status     = apply_command(c, d);
    v.slot_valid = (cur_node != NIL);
    v.slot       = v.slot_valid ? cur_node[7:0] : 8'd0;
    v.node_data  = v.slot_valid ? slot_data[cur_node[SW-1:0]] : '0;
    pending_views.push_back(v);
  endfunction

  task automatic send_word(input cmd_t c, input data_t d);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.data  <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_view(c, d);
    words_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    hold_input();
    while (pending_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mask(input data_t m);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_COMPARE_MASK;
    cfg_pwdata  <= m;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    key_mask = m;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    node_view_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected word status=%0d slot=%0d", $time, out_ch.status,
                 out_ch.slot);
        fail_count++;
      end else begin
        e = pending_views.pop_front();
        if (out_ch.status !== e.status || out_ch.slot !== e.slot ||
            out_ch.slot_valid !== e.slot_valid || out_ch.node_data !== e.node_data) begin
          $display("%0t: mismatch expected st=%0d slot=%0d v=%0b data=%h", $time,
                   e.status, e.slot, e.slot_valid, e.node_data);
          $display("%0t:          actual   st=%0d slot=%0d v=%0b data=%h", $time,
                   out_ch.status, out_ch.slot, out_ch.slot_valid, out_ch.node_data);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_views.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_word(CMD_READ_CUR, 32'h0);
    send_word(CMD_RM_FRONT, 32'h0);
    send_word(CMD_RM_REAR, 32'h0);
    send_word(CMD_RM_CUR, 32'h0);
    send_word(CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, 32'h0);
  endtask

  task automatic test_basic_ops();
    send_word(CMD_INS_REAR, 32'h0000_0000);
    send_word(CMD_INS_REAR, 32'hFFFF_FFFF);
    send_word(CMD_INS_FRONT, 32'hA5A5_5A5A);
    send_word(CMD_INS_REAR, 32'h1234_5678);
    send_word(CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(CMD_RM_CUR, 32'h0);
    send_word(CMD_SEARCH, 32'h0BAD_F00D);
    send_word(CMD_SEARCH, 32'hA5A5_5A5A);
    send_word(CMD_RM_CUR, 32'h0);
    send_word(CMD_READ_CUR, 32'h0);
    send_word(CMD_RM_REAR, 32'h0);
    send_word(CMD_INS_FRONT, 32'h5A5A_A5A5);
    send_word(CMD_RM_REAR, 32'h0);
    send_word(CMD_RM_REAR, 32'h0);
    send_word(CMD_RM_CUR, 32'h0);
    send_word(CMD_INS_FRONT, 32'h8000_0001);
    send_word(CMD_CLEAR, 32'h0);
    send_word(CMD_READ_CUR, 32'h0);
    send_word(CMD_RM_CUR, 32'h0);
  endtask

  task automatic test_fill_to_full();
    repeat (SLOTS + 2) send_word(CMD_INS_FRONT, $urandom);
    send_word(CMD_INS_REAR, $urandom);
    send_word(CMD_RM_REAR, 32'h0);
    send_word(CMD_INS_REAR, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, 32'h0);
  endtask

  task automatic test_random(input data_t m, input int count);
    int k, r, len, hop;
    ptr_t p;
    cmd_t c;
    data_t d;
    write_mask(m);
    for (k = 0; k < count; k++) begin
      calm = (k >= count / 3 && k < count / 3 + 60);
      len = list_length();
      r = $urandom_range(99);
      if (len > 24) r = (r < 50) ? 30 + r / 2 : r;
      if (r < 20) c = CMD_INS_FRONT;
      else if (r < 40) c = CMD_INS_REAR;
      else if (r < 50) c = CMD_RM_FRONT;
      else if (r < 60) c = CMD_RM_REAR;
      else if (r < 72) c = CMD_RM_CUR;
      else if (r < 90) c = CMD_SEARCH;
      else if (r < 92) c = CMD_CLEAR;
      else c = CMD_READ_CUR;
      d = $urandom;
      if (c == CMD_SEARCH && len > 0 && $urandom_range(99) < 70) begin
        p = list_head;
        for (hop = $urandom_range(len - 1); hop > 0; hop--) p = succ(p);
        d = slot_data[p[SW-1:0]] ^ ($urandom & ~m);
      end
      send_word(c, d);
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    words_sent    = 0;
    calm          = 1'b0;
    list_head     = NIL;
    cur_node      = NIL;
    free_top      = NIL;
    fresh_count   = '0;
    key_mask      = '1;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_READ_CUR;
    in_ch.data    = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = REG_COMPARE_MASK;
    cfg_pwdata    = '0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mask(32'hFFFF_FFFF);
    test_empty_list();
    test_basic_ops();
    drain();
    test_fill_to_full();
    drain();
    test_random(32'hFFFF_FFFF, 400);
    test_random(32'h0000_0000, 250);
    test_random(32'h0000_FFFF, 300);
    test_random($urandom, 350);

    $display("sent %0d command words, checked %0d result words", words_sent,
             words_checked);
    $display("covered empty list, full store, free list reuse and four search masks");
    if (fail_count == 0 && pending_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
